[src/mkdb_pkg.sv]
`timescale 1ns / 1ps

package mkdb_pkg;

  localparam int NUM_KEYS         = 4;
  localparam int EVENT_BIT_OFFSET = 12;

  localparam int KEY_W    = 4;
  localparam int TIMER_W  = 16;
  localparam int DATA_W   = 16;
  localparam int ACTION_W = 2;

  localparam logic [TIMER_W-1:0] DEBOUNCE_RESET = 16'd20;

  localparam logic [ACTION_W-1:0] ACT_TICK        = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ_STATE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ_EVENTS = 2'd2;

  typedef struct packed {
    logic               tick;
    logic               sample;
    logic               clr_event;
    logic [TIMER_W-1:0] reload;
  } lane_ctrl_t;

  typedef struct packed {
    logic stable;
    logic event_flag;
  } lane_stat_t;

endpackage

[src/mkdb_lane.sv]
`timescale 1ns / 1ps

module mkdb_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  mkdb_pkg::lane_ctrl_t ctrl,
  output mkdb_pkg::lane_stat_t stat
);

  logic [mkdb_pkg::TIMER_W-1:0] timer_r;
  logic [mkdb_pkg::TIMER_W-1:0] timer_dec;
  logic                         raw_r;
  logic                         stable_r;
  logic                         event_r;

  assign timer_dec = (timer_r != '0) ? timer_r - 1'b1 : timer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r  <= mkdb_pkg::DEBOUNCE_RESET;
      raw_r    <= 1'b1;
      stable_r <= 1'b0;
      event_r  <= 1'b0;
    end else if (ctrl.tick) begin
      if (ctrl.sample != raw_r) begin
        raw_r   <= ctrl.sample;
        timer_r <= ctrl.reload;
      end else begin
        timer_r <= timer_dec;
        if (timer_dec == {{(mkdb_pkg::TIMER_W-1){1'b0}}, 1'b1}) begin
          stable_r <= ~raw_r;
          if (!raw_r) begin
            event_r <= 1'b1;
          end
        end
      end
    end else if (ctrl.clr_event) begin
      event_r <= 1'b0;
    end
  end

  assign stat.stable     = stable_r;
  assign stat.event_flag = event_r;

endmodule

[src/mkdb_merge.sv]
`timescale 1ns / 1ps

module mkdb_merge (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            req_fire,
  input  logic [mkdb_pkg::ACTION_W-1:0]   req_action,
  input  logic [mkdb_pkg::DATA_W-1:0]     req_mask,
  input  logic [mkdb_pkg::NUM_KEYS-1:0]   stable_keys,
  input  logic [mkdb_pkg::NUM_KEYS-1:0]   event_keys,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [mkdb_pkg::DATA_W-1:0]     out_read_data
);

  logic                          valid_r;
  logic                          valid_nxt;
  logic [mkdb_pkg::DATA_W-1:0]   data_r;
  logic [mkdb_pkg::DATA_W-1:0]   state_word;
  logic [mkdb_pkg::DATA_W-1:0]   event_word;
  logic [mkdb_pkg::DATA_W-1:0]   data_nxt;
  logic                          is_read;

  always_comb begin
    state_word = '0;
    event_word = '0;
    for (int i = 0; i < mkdb_pkg::NUM_KEYS; i++) begin
      state_word[i]                             = stable_keys[i];
      event_word[mkdb_pkg::EVENT_BIT_OFFSET + i] = event_keys[i];
    end
  end

  always_comb begin
    is_read  = 1'b0;
    data_nxt = '0;
    unique case (req_action)
      mkdb_pkg::ACT_READ_STATE: begin
        is_read  = 1'b1;
        data_nxt = state_word & req_mask;
      end
      mkdb_pkg::ACT_READ_EVENTS: begin
        is_read  = 1'b1;
        data_nxt = event_word & req_mask;
      end
      default: begin
        is_read  = 1'b0;
        data_nxt = '0;
      end
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (req_fire && is_read) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire && is_read) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_read_data = data_r;

endmodule

[src/multi_key_debouncer_with_events.sv]
`timescale 1ns / 1ps
// channel  | ports                                      | direction
// in       | in_valid in_ready in_action in_raw_keys     | request in
//          | in_key_mask                                |
// out      | out_valid out_ready out_read_data          | result out
// cfg      | cfg_wr_en cfg_wr_data                      | register write
//
// one request per cycle while in_ready is high; a tick updates all key lanes in parallel in that cycle
// a read's result is registered and shown from the output register in the cycle after its acceptance
// a request is taken while the output register is empty or being drained
// reset restores all keys released, timers at the default reload and no events

module multi_key_debouncer_with_events (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mkdb_pkg::ACTION_W-1:0] in_action,
  input  logic [mkdb_pkg::KEY_W-1:0]    in_raw_keys,
  input  logic [mkdb_pkg::DATA_W-1:0]   in_key_mask,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mkdb_pkg::DATA_W-1:0]   out_read_data,
  input  logic                          cfg_wr_en,
  input  logic [mkdb_pkg::TIMER_W-1:0]  cfg_wr_data
);

  logic [mkdb_pkg::TIMER_W-1:0]   debounce_ticks_r;
  logic                           in_fire;
  logic [mkdb_pkg::NUM_KEYS-1:0]  stable_keys;
  logic [mkdb_pkg::NUM_KEYS-1:0]  event_keys;
  mkdb_pkg::lane_ctrl_t           lane_ctrl [mkdb_pkg::NUM_KEYS];
  mkdb_pkg::lane_stat_t           lane_stat [mkdb_pkg::NUM_KEYS];

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r <= mkdb_pkg::DEBOUNCE_RESET;
    end else if (cfg_wr_en) begin
      debounce_ticks_r <= cfg_wr_data;
    end
  end

  for (genvar g = 0; g < mkdb_pkg::NUM_KEYS; g++) begin : g_lane
    assign lane_ctrl[g].tick      = in_fire && (in_action == mkdb_pkg::ACT_TICK);
    assign lane_ctrl[g].sample    = in_raw_keys[g];
    assign lane_ctrl[g].clr_event = in_fire && (in_action == mkdb_pkg::ACT_READ_EVENTS)
                                    && in_key_mask[mkdb_pkg::EVENT_BIT_OFFSET + g];
    assign lane_ctrl[g].reload    = debounce_ticks_r;

    mkdb_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (lane_ctrl[g]),
      .stat  (lane_stat[g])
    );

    assign stable_keys[g] = lane_stat[g].stable;
    assign event_keys[g]  = lane_stat[g].event_flag;
  end

  mkdb_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_fire      (in_fire),
    .req_action    (in_action),
    .req_mask      (in_key_mask),
    .stable_keys   (stable_keys),
    .event_keys    (event_keys),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_read_data (out_read_data)
  );

  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_action == mkdb_pkg::ACT_READ_STATE ||
                in_action == mkdb_pkg::ACT_READ_EVENTS) |=> out_valid)
    else $error("read request produced no result");

  a_tick_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !out_valid && (in_action == mkdb_pkg::ACT_TICK) |=> !out_valid)
    else $error("tick produced a result");

  a_event_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_action == mkdb_pkg::ACT_READ_EVENTS) &&
    (in_key_mask[mkdb_pkg::EVENT_BIT_OFFSET +: mkdb_pkg::NUM_KEYS] == '1)
    |=> (event_keys == '0))
    else $error("event bits not cleared by full mask");

endmodule

[tb/multi_key_debouncer_with_events_tb.sv]
`timescale 1ns / 1ps

module multi_key_debouncer_with_events_tb;

  typedef logic [mkdb_pkg::ACTION_W-1:0] action_t;
  typedef logic [mkdb_pkg::KEY_W-1:0]    keys_t;
  typedef logic [mkdb_pkg::DATA_W-1:0]   data_t;
  typedef logic [mkdb_pkg::TIMER_W-1:0]  timer_t;

  localparam action_t ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int NUM_PHASES = 10;

  typedef struct packed {
    action_t action;
    keys_t   raw_keys;
    data_t   key_mask;
  } request_t;

  logic    clk;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  action_t in_action = '0;
  keys_t   in_raw_keys = '0;
  data_t   in_key_mask = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  data_t   out_read_data;
  logic    cfg_wr_en = 1'b0;
  timer_t  cfg_wr_data = '0;

  request_t pending_requests[$];
  data_t    expected_reads[$];
  request_t next_req;
  data_t    exp_data;

  // predicted block state
  timer_t reload_ticks;
  keys_t  raw_seen;
  keys_t  stable_keys;
  keys_t  key_events;
  timer_t key_count [mkdb_pkg::NUM_KEYS];

  int send_idle_pct = 34;
  int recv_idle_pct = 71;
  int errors = 0;
  int cycle_count = 0;
  int item_count = 0;
  timer_t phase_reload [NUM_PHASES] = '{16'd3, 16'd2, 16'd20, 16'd65535, 16'd5,
                                        16'd1, 16'd0, 16'd2, 16'd4, 16'd9};

  multi_key_debouncer_with_events u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_raw_keys   (in_raw_keys),
    .in_key_mask   (in_key_mask),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic apply_request(input request_t r);
    unique case (r.action)
      mkdb_pkg::ACT_TICK: begin
        for (int i = 0; i < mkdb_pkg::NUM_KEYS; i++) begin
          if (key_count[i] != '0) key_count[i] = key_count[i] - 1'b1;
        end
        for (int i = 0; i < mkdb_pkg::NUM_KEYS; i++) begin
          if (r.raw_keys[i] != raw_seen[i]) begin
            raw_seen[i] = r.raw_keys[i];
            key_count[i] = reload_ticks;
          end else if (key_count[i] == 16'd1) begin
            stable_keys[i] = ~raw_seen[i];
            if (stable_keys[i]) key_events[i] = 1'b1;
          end
        end
      end
      mkdb_pkg::ACT_READ_STATE: begin
        expected_reads.push_back({{(mkdb_pkg::DATA_W-mkdb_pkg::KEY_W){1'b0}}, stable_keys}
                                 & r.key_mask);
      end
      mkdb_pkg::ACT_READ_EVENTS: begin
        expected_reads.push_back(
          data_t'({key_events, {mkdb_pkg::EVENT_BIT_OFFSET{1'b0}}}) & r.key_mask);
        key_events = key_events
                     & ~r.key_mask[mkdb_pkg::EVENT_BIT_OFFSET +: mkdb_pkg::KEY_W];
      end
      default: begin
      end
    endcase
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_request({in_action, in_raw_keys, in_key_mask});
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_action <= next_req.action;
          in_raw_keys <= next_req.raw_keys;
          in_key_mask <= next_req.key_mask;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (expected_reads.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, out_read_data);
        errors++;
      end else begin
        exp_data = expected_reads.pop_front();
        if (out_read_data !== exp_data) begin
          $display("%0t: read_data mismatch: expected %h, actual %h",
                   $time, exp_data, out_read_data);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic data_t pick_mask();
    case ($urandom_range(3))
      0: pick_mask = '1;
      1: pick_mask = 16'hF000;
      2: pick_mask = 16'h000F;
      default: pick_mask = data_t'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic queue_request(input action_t action,
                               input keys_t raw_keys,
                               input data_t key_mask);
    request_t r;
    r.action = action;
    r.raw_keys = raw_keys;
    r.key_mask = key_mask;
    pending_requests.push_back(r);
    if (action != ACT_UNUSED) item_count++;
  endtask

  task automatic queue_read();
    queue_request($urandom_range(1) ? mkdb_pkg::ACT_READ_STATE : mkdb_pkg::ACT_READ_EVENTS,
                  keys_t'($urandom_range(15)), pick_mask());
  endtask

  // bounce, then hold a new level (around the commit point when the reload is 2 to 24) with reads mixed in
  task automatic queue_press_sequence();
    keys_t target;
    int hold;
    target = keys_t'($urandom_range(15));
    repeat ($urandom_range(3)) begin
      queue_request(mkdb_pkg::ACT_TICK, keys_t'($urandom_range(15)), pick_mask());
    end
    if (reload_ticks >= 16'd2 && reload_ticks <= 16'd24) begin
      hold = int'(reload_ticks) - 1 + int'($urandom_range(2));
    end else begin
      hold = int'($urandom_range(1, 12));
    end
    repeat (hold) begin
      queue_request(mkdb_pkg::ACT_TICK, target, pick_mask());
      if ($urandom_range(99) < 25) queue_read();
    end
  endtask

  task automatic queue_noise();
    queue_request(action_t'($urandom_range(3)), keys_t'($urandom_range(15)),
                  data_t'($urandom_range(16'hFFFF)));
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_reads.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_reload(input timer_t value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    reload_ticks = value;
  endtask

  initial begin
    reload_ticks = mkdb_pkg::DEBOUNCE_RESET;
    raw_seen = '1;
    stable_keys = '0;
    key_events = '0;
    for (int i = 0; i < mkdb_pkg::NUM_KEYS; i++) key_count[i] = mkdb_pkg::DEBOUNCE_RESET;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    set_reload(16'd2);
    queue_request(mkdb_pkg::ACT_READ_STATE, 4'h0, 16'hFFFF);
    queue_request(mkdb_pkg::ACT_READ_EVENTS, 4'hF, 16'hFFFF);
    queue_request(ACT_UNUSED, 4'hF, 16'hFFFF);
    queue_request(mkdb_pkg::ACT_TICK, 4'h0, 16'h0000);
    queue_request(mkdb_pkg::ACT_TICK, 4'h0, 16'hFFFF);
    queue_request(mkdb_pkg::ACT_READ_STATE, 4'h0, 16'hFFFF);
    queue_request(mkdb_pkg::ACT_READ_STATE, 4'h0, 16'h0000);
    queue_request(mkdb_pkg::ACT_READ_EVENTS, 4'h0, 16'h5000);
    queue_request(mkdb_pkg::ACT_READ_EVENTS, 4'h0, 16'hFFFF);
    queue_request(mkdb_pkg::ACT_READ_EVENTS, 4'h0, 16'hFFFF);
    queue_request(mkdb_pkg::ACT_TICK, 4'hF, 16'h0000);
    queue_request(mkdb_pkg::ACT_TICK, 4'hF, 16'h0000);
    queue_request(mkdb_pkg::ACT_READ_STATE, 4'h0, 16'hFFFF);
    queue_request(mkdb_pkg::ACT_TICK, 4'h5, 16'h0000);
    queue_request(mkdb_pkg::ACT_TICK, 4'hA, 16'h0000);
    queue_request(mkdb_pkg::ACT_TICK, 4'hA, 16'h0000);
    queue_request(mkdb_pkg::ACT_READ_STATE, 4'h0, 16'hFFFF);
    queue_request(mkdb_pkg::ACT_READ_EVENTS, 4'h0, 16'h0FFF);
    queue_request(mkdb_pkg::ACT_READ_EVENTS, 4'h0, 16'hFFFF);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 4) begin
        send_idle_pct = 71;
        recv_idle_pct = 34;
      end else if (p == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_reload(phase_reload[p]);
      item_count = 0;
      while (item_count < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 80) queue_press_sequence();
        else repeat ($urandom_range(1, 4)) queue_noise();
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
